### sv/assert_macros.svh
// Assertion macros shared by the checker modules of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is disabled while reset is asserted.
`define CHCV_ASSERT_DIS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also runs through reset.
`define CHCV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### sv/chcv_pkg.sv
// Types, constants and the FNV-1a 64 step for the header checksum validator.
// No dependencies.
package chcv_pkg;

    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [IDX_W-1:0] HDR_BYTES = 5'd28;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VERSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION = 1'b1;

    localparam logic [31:0] MIN_VERSION_RST = 32'd2;
    localparam logic [31:0] MAX_VERSION_RST = 32'd3;

    localparam logic [63:0] OFFSET_STD    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] OFFSET_LEGACY = 64'd1469598103934665603;

    // Payload length stops here: the whole-file byte count saturates at all ones.
    localparam logic [63:0] PLEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF - 64'd28;

    // File magic "VTX3D001", first byte first.
    localparam logic [7:0] MAGIC [8] = '{8'h56, 8'h54, 8'h58, 8'h33,
                                         8'h44, 8'h30, 8'h30, 8'h31};

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_SUM     = 3'd4
    } t_status;

    // File state after its last byte, handed to the status stage.
    typedef struct packed {
        logic        short_file;
        logic        magic_ok;
        logic [31:0] version;
        logic [63:0] declared;
        logic [63:0] expected;
        logic [63:0] hash_std;
        logic [63:0] hash_leg;
        logic [63:0] plen;
    } t_snap;

    // One FNV-1a 64 step; the prime 2^40 + 0x1B3 is applied as shifts and adds.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
    endfunction

endpackage

### sv/chcv_hdr_parse.sv
// Per-file state: header field capture, magic check, payload hashes and count.
// Depends on chcv_pkg.
module chcv_hdr_parse import chcv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_snap       o_snap
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_magic_ok, n_magic_ok;
    logic [31:0]      r_version, n_version;
    logic [63:0]      r_declared, n_declared;
    logic [63:0]      r_expected, n_expected;
    logic [63:0]      r_hash_std, n_hash_std;
    logic [63:0]      r_hash_leg, n_hash_leg;
    logic [63:0]      r_plen, n_plen;
    logic [IDX_W-1:0] decl_pos;
    logic [IDX_W-1:0] sum_pos;

    assign decl_pos = r_idx - 5'd12;
    assign sum_pos  = r_idx - 5'd20;

    // Updated state including the current byte.
    always_comb begin
        n_idx      = (r_idx == HDR_BYTES) ? r_idx : r_idx + 5'd1;
        n_magic_ok = r_magic_ok;
        n_version  = r_version;
        n_declared = r_declared;
        n_expected = r_expected;
        n_hash_std = r_hash_std;
        n_hash_leg = r_hash_leg;
        n_plen     = r_plen;
        priority if (r_idx < 5'd8) begin
            n_magic_ok = r_magic_ok && (i_byte == MAGIC[r_idx[2:0]]);
        end else if (r_idx < 5'd12) begin
            n_version[{r_idx[1:0], 3'b000} +: 8] = i_byte;
        end else if (r_idx < 5'd20) begin
            n_declared[{decl_pos[2:0], 3'b000} +: 8] = i_byte;
        end else if (r_idx < HDR_BYTES) begin
            n_expected[{sum_pos[2:0], 3'b000} +: 8] = i_byte;
        end else begin
            n_hash_std = fnv_step(r_hash_std, i_byte);
            n_hash_leg = fnv_step(r_hash_leg, i_byte);
            if (r_plen != PLEN_MAX) begin
                n_plen = r_plen + 64'd1;
            end
        end
    end

    always_comb begin
        o_snap.short_file = (n_idx < HDR_BYTES);
        o_snap.magic_ok   = n_magic_ok;
        o_snap.version    = n_version;
        o_snap.declared   = n_declared;
        o_snap.expected   = n_expected;
        o_snap.hash_std   = n_hash_std;
        o_snap.hash_leg   = n_hash_leg;
        o_snap.plen       = n_plen;
    end

    // Drop back to the empty-file state after the last beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_idx      <= '0;
            r_magic_ok <= 1'b1;
            r_version  <= '0;
            r_declared <= '0;
            r_expected <= '0;
            r_hash_std <= OFFSET_STD;
            r_hash_leg <= OFFSET_LEGACY;
            r_plen     <= '0;
        end else if (i_en) begin
            r_idx      <= n_idx;
            r_magic_ok <= n_magic_ok;
            r_version  <= n_version;
            r_declared <= n_declared;
            r_expected <= n_expected;
            r_hash_std <= n_hash_std;
            r_hash_leg <= n_hash_leg;
            r_plen     <= n_plen;
        end
    end

endmodule

### sv/chcv_status.sv
// Final status decision from a captured file state and the version window.
// Depends on chcv_pkg.
module chcv_status import chcv_pkg::*; (
    input  t_snap       i_snap,
    input  logic [31:0] i_min_version,
    input  logic [31:0] i_max_version,
    output t_status     o_status
);

    logic version_bad;
    logic length_bad;
    logic sum_bad;

    assign version_bad = (i_snap.version < i_min_version) || (i_snap.version > i_max_version);
    assign length_bad  = (i_snap.declared != i_snap.plen);
    assign sum_bad     = (i_snap.expected != i_snap.hash_std)
                      && (i_snap.expected != i_snap.hash_leg);

    always_comb begin
        priority if (i_snap.short_file) begin
            o_status = ST_TRUNCATED;
        end else if (!i_snap.magic_ok) begin
            o_status = ST_BAD_MAGIC;
        end else if (version_bad) begin
            o_status = ST_BAD_VERSION;
        end else if (length_bad) begin
            o_status = ST_TRUNCATED;
        end else if (sum_bad) begin
            o_status = ST_BAD_SUM;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

### sv/container_header_checksum_validator_unit.sv
// Checked file header validator: one file byte per beat in, one status per file out.
// Depends on chcv_pkg, chcv_hdr_parse and chcv_status.
//
// Stream a file in byte by byte on the input channel and mark its final byte with
// i_last_byte; one result beat follows for each file. The first 28 bytes are the
// header (8-byte magic, little-endian 32-bit version, 64-bit payload length and
// 64-bit checksum); every later byte runs through two FNV-1a 64 hashes, one from the
// standard offset basis and one from the legacy offset. The status is, in priority
// order: truncated if fewer than 28 bytes came, bad magic, unsupported version if the
// version lies outside [min_version, max_version] (an empty window rejects every
// version), truncated if the declared length differs from the bytes received after
// the header, checksum mismatch if the checksum equals neither hash, else ok. The
// block takes one byte every cycle, back to back, with no gaps between files, save
// for the stall named below; the hash update (xor plus a shift-and-add multiply by
// the sparse FNV prime) is combinational. The input register takes the last byte,
// the capture stage then registers the file state, and the result register loads
// the status computed from it. The result register and the capture stage decouple
// the sides, so bytes keep flowing while a result waits; only a further last byte
// stalls, when both are full and the result is not taken. Write min_version
// (index 0) and max_version (index 1) only while no file is in flight.
module container_header_checksum_validator_unit import chcv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    // byte stream
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [31:0]          o_version_seen,
    output logic [63:0]          o_payload_hash,
    output logic [63:0]          o_payload_length
);

    logic [31:0] r_min_version;
    logic [31:0] r_max_version;

    // input register
    logic        r_a_valid;
    logic [7:0]  r_a_byte;
    logic        r_a_last;

    // captured file state for the status stage
    logic        r_b_valid;
    t_snap       r_b_snap;

    // result register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_version;
    logic [63:0] r_out_hash;
    logic [63:0] r_out_plen;

    logic        c_ready;
    logic        b_ready;
    logic        a_fire;
    logic        in_fire;
    t_snap       snap;
    t_status     status;

    // Ready flows back stage by stage; a byte that is not last never waits on the result side.
    assign c_ready    = !r_out_valid || i_out_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_fire     = r_a_valid && (!r_a_last || b_ready);
    assign o_in_ready = !r_a_valid || a_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // Configuration registers; both index codes are defined, so every write lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_version <= MIN_VERSION_RST;
            r_max_version <= MAX_VERSION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_VERSION: r_min_version <= i_cfg_wdata;
                CFG_MAX_VERSION: r_max_version <= i_cfg_wdata;
                default:         r_max_version <= r_max_version;
            endcase
        end
    end

    // Input register: hold the beat until the state stage consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_byte <= i_data_byte;
            r_a_last <= i_last_byte;
        end
    end

    chcv_hdr_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (a_fire),
        .i_byte  (r_a_byte),
        .i_last  (r_a_last),
        .o_snap  (snap)
    );

    // Capture the file state on its last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_fire && r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && a_fire && r_a_last) begin
            r_b_snap <= snap;
        end
    end

    chcv_status u_status (
        .i_snap        (r_b_snap),
        .i_min_version (r_min_version),
        .i_max_version (r_max_version),
        .o_status      (status)
    );

    // Result register: advance when empty or when the consumer takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_out_status  <= status;
            r_out_version <= r_b_snap.version;
            r_out_hash    <= r_b_snap.hash_std;
            r_out_plen    <= r_b_snap.plen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_version_seen   = r_out_version;
    assign o_payload_hash   = r_out_hash;
    assign o_payload_length = r_out_plen;

endmodule

### sv/chcv_checker.sv
// Port-level checks for the header checksum validator, bound to its top level.
// Depends on chcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chcv_checker import chcv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 i_last_byte,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [2:0]           o_status,
    input  logic [31:0]          o_version_seen,
    input  logic [63:0]          o_payload_hash
);

    logic [31:0] r_min;
    logic [31:0] r_max;
    logic [2:0]  r_pending;
    logic        last_fire;
    logic        out_fire;

    assign last_fire = i_in_valid && o_in_ready && i_last_byte;
    assign out_fire  = o_out_valid && i_out_ready;

    // Shadow the version window from the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_VERSION_RST;
            r_max <= MAX_VERSION_RST;
        end else if (i_cfg_we && (i_cfg_index == CFG_MIN_VERSION)) begin
            r_min <= i_cfg_wdata;
        end else if (i_cfg_we && (i_cfg_index == CFG_MAX_VERSION)) begin
            r_max <= i_cfg_wdata;
        end
    end

    // Files whose last byte went in and whose result has not come out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(last_fire) - 3'(out_fire);
        end
    end

    `CHCV_ASSERT_DIS(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) && $stable(o_payload_hash)), "result beat changed while stalled")
    `CHCV_ASSERT_DIS(a_no_spurious_result, i_clk, i_rst_n, out_fire |-> (r_pending != 3'd0), "result without an accepted last byte")
    `CHCV_ASSERT_DIS(a_version_window, i_clk, i_rst_n, (o_out_valid && (o_status == ST_OK || o_status == ST_BAD_SUM)) |-> (o_version_seen >= r_min && o_version_seen <= r_max), "version passed outside the window")
    `CHCV_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

bind container_header_checksum_validator_unit chcv_checker u_chcv_checker (.*);
